FILE: design/isp_header_parse_fbaq4_decode_unit_defines.svh
// Assertion macros shared by the header parser and the result queue.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ISP_HEADER_PARSE_FBAQ4_DECODE_UNIT_DEFINES_SVH
`define ISP_HEADER_PARSE_FBAQ4_DECODE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every clock edge outside reset.
`define ISP_HDR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ISP_HDR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define ISP_HDR_ASSERT(lbl, prop, msg)
`define ISP_HDR_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

FILE: design/isp_hdr_pkg.sv
`timescale 1ns / 1ps

package isp_hdr_pkg;

  // Packet framing
  localparam int HDR_BYTES   = 36;
  localparam int HDR_POS_W   = $clog2(HDR_BYTES);
  localparam int LEN_W       = 16;
  localparam int BLOCK_BYTES = 64;
  localparam int BLK_OFF_W   = (BLOCK_BYTES > 2) ? $clog2(BLOCK_BYTES) : 1;

  localparam logic [LEN_W-1:0] DFH_LEN = LEN_W'(29);
  localparam logic [7:0]       MODE_IM = 8'h54;

  // Header byte positions
  localparam logic [HDR_POS_W-1:0] P_START      = HDR_POS_W'(0);
  localparam logic [HDR_POS_W-1:0] P_LEN_HI     = HDR_POS_W'(4);
  localparam logic [HDR_POS_W-1:0] P_LEN_LO     = HDR_POS_W'(5);
  localparam logic [HDR_POS_W-1:0] P_DFH_HI     = HDR_POS_W'(6);
  localparam logic [HDR_POS_W-1:0] P_DFH_LO     = HDR_POS_W'(7);
  localparam logic [HDR_POS_W-1:0] P_MODE_ID    = HDR_POS_W'(9);
  localparam logic [HDR_POS_W-1:0] P_TIME_FIRST = HDR_POS_W'(10);
  localparam logic [HDR_POS_W-1:0] P_TIME_LAST  = HDR_POS_W'(14);
  localparam logic [HDR_POS_W-1:0] P_MCNT_FIRST = HDR_POS_W'(16);
  localparam logic [HDR_POS_W-1:0] P_MCNT_LAST  = HDR_POS_W'(18);
  localparam logic [HDR_POS_W-1:0] P_FLAGS      = HDR_POS_W'(20);
  localparam logic [HDR_POS_W-1:0] P_CYCLE_LO   = HDR_POS_W'(21);
  localparam logic [HDR_POS_W-1:0] P_PRI_HI     = HDR_POS_W'(22);
  localparam logic [HDR_POS_W-1:0] P_PRI_LO     = HDR_POS_W'(23);
  localparam logic [HDR_POS_W-1:0] P_SWST_HI    = HDR_POS_W'(24);
  localparam logic [HDR_POS_W-1:0] P_SWST_LO    = HDR_POS_W'(25);
  localparam logic [HDR_POS_W-1:0] P_WIN_HI     = HDR_POS_W'(26);
  localparam logic [HDR_POS_W-1:0] P_WIN_LO     = HDR_POS_W'(27);
  localparam logic [HDR_POS_W-1:0] P_LAST       = HDR_POS_W'(HDR_BYTES - 1);

  // Reconstruction tables
  localparam int TABLE_DEPTH = 4096;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);
  localparam int WORD_W      = 32;

  localparam logic [3:0] CODE_MAX  = 4'hF;
  localparam logic [3:0] CODE_BIAS = 4'd8;

  // Result queue
  localparam int OQ_DEPTH = 3;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  typedef enum logic {
    REQ_STREAM = 1'b0,
    REQ_TABLE  = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    RES_HEADER = 2'd0,
    RES_SAMPLE = 2'd1,
    RES_ERROR  = 2'd2
  } result_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_DFH_LEN = 2'd1,
    ERR_MODE_ID = 2'd2
  } err_code_e;

  typedef struct packed {
    result_kind_e      kind;
    err_code_e         err;
    logic [39:0]       board_time;
    logic [23:0]       mode_counter;
    logic [3:0]        flag_bits;
    logic [11:0]       cycle_counter;
    logic [15:0]       pri_value;
    logic [15:0]       swst_value;
    logic [15:0]       window_length;
    logic [WORD_W-1:0] i_recon;
    logic [WORD_W-1:0] q_recon;
    logic              last_sample;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [TBL_AW-1:0] i_addr;
    logic [TBL_AW-1:0] q_addr;
  } lut_rd_t;

  typedef struct packed {
    logic              en;
    logic [TBL_AW-1:0] addr;
    logic [WORD_W-1:0] i_word;
    logic [WORD_W-1:0] q_word;
  } lut_wr_t;

  // Fold a 4-bit code: 8..15 maps to 15-code, 0..7 to code+8.
  function automatic logic [3:0] map_code(logic [3:0] c);
    logic [3:0] m;
    if (c[3]) begin
      m = CODE_MAX - c;
    end else begin
      m = c + CODE_BIAS;
    end
    return m;
  endfunction

endpackage

FILE: design/isp_hdr_lut.sv
`timescale 1ns / 1ps

module isp_hdr_lut (
  input  logic                               clk_i,
  input  isp_hdr_pkg::lut_wr_t               wr_i,
  input  isp_hdr_pkg::lut_rd_t               rd_i,
  output logic [isp_hdr_pkg::WORD_W-1:0]     i_rdata_o,
  output logic [isp_hdr_pkg::WORD_W-1:0]     q_rdata_o
);

  logic [isp_hdr_pkg::WORD_W-1:0] i_tbl_q [isp_hdr_pkg::TABLE_DEPTH];
  logic [isp_hdr_pkg::WORD_W-1:0] q_tbl_q [isp_hdr_pkg::TABLE_DEPTH];
  logic [isp_hdr_pkg::WORD_W-1:0] i_rdata_q;
  logic [isp_hdr_pkg::WORD_W-1:0] q_rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      i_tbl_q[wr_i.addr] <= wr_i.i_word;
    end
    if (rd_i.en) begin
      i_rdata_q <= i_tbl_q[rd_i.i_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      q_tbl_q[wr_i.addr] <= wr_i.q_word;
    end
    if (rd_i.en) begin
      q_rdata_q <= q_tbl_q[rd_i.q_addr];
    end
  end

  assign i_rdata_o = i_rdata_q;
  assign q_rdata_o = q_rdata_q;

endmodule

FILE: design/isp_hdr_parse.sv
`timescale 1ns / 1ps
`include "isp_header_parse_fbaq4_decode_unit_defines.svh"

module isp_hdr_parse (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           byte_i,
  output isp_hdr_pkg::lut_rd_t rd_o,
  output logic                 res_valid_o,
  output isp_hdr_pkg::result_t res_o
);

  localparam logic [isp_hdr_pkg::BLK_OFF_W-1:0] BlkOffLast =
    isp_hdr_pkg::BLK_OFF_W'(isp_hdr_pkg::BLOCK_BYTES - 1);
  localparam logic [isp_hdr_pkg::LEN_W-1:0] BlkLen =
    isp_hdr_pkg::LEN_W'(isp_hdr_pkg::BLOCK_BYTES);
  localparam logic [isp_hdr_pkg::LEN_W-1:0] RemOne = isp_hdr_pkg::LEN_W'(1);

  // Control state
  logic [isp_hdr_pkg::HDR_POS_W-1:0] pos_q, pos_d;
  logic                              in_data_q, in_data_d;
  logic                              skip_q, skip_d;
  logic [isp_hdr_pkg::LEN_W-1:0]     rem_q, rem_d;
  logic [isp_hdr_pkg::BLK_OFF_W-1:0] blk_off_q, blk_off_d;
  logic                              blk_full_q, blk_full_d;
  logic                              res_valid_q, res_valid_d;

  // Header shadow and payload
  logic [isp_hdr_pkg::LEN_W-1:0] len_q, len_d;
  logic [15:0]                   dfh_q, dfh_d;
  logic [39:0]                   time_q, time_d;
  logic [23:0]                   mcnt_q, mcnt_d;
  logic [3:0]                    flags_q, flags_d;
  logic [11:0]                   cycle_q, cycle_d;
  logic [15:0]                   pri_q, pri_d;
  logic [15:0]                   swst_q, swst_d;
  logic [15:0]                   win_q, win_d;
  logic [7:0]                    blk_id_q, blk_id_d;
  isp_hdr_pkg::result_t          res_q, res_d;

  logic full_now;

  always_comb begin
    pos_d       = pos_q;
    in_data_d   = in_data_q;
    skip_d      = skip_q;
    rem_d       = rem_q;
    blk_off_d   = blk_off_q;
    blk_full_d  = blk_full_q;
    res_valid_d = 1'b0;
    len_d       = len_q;
    dfh_d       = dfh_q;
    time_d      = time_q;
    mcnt_d      = mcnt_q;
    flags_d     = flags_q;
    cycle_d     = cycle_q;
    pri_d       = pri_q;
    swst_d      = swst_q;
    win_d       = win_q;
    blk_id_d    = blk_id_q;
    res_d       = '0;
    rd_o        = '0;
    full_now    = 1'b0;

    if (accept_i && !in_data_q) begin
      if (pos_q == isp_hdr_pkg::P_START) begin
        dfh_d   = '0;
        time_d  = '0;
        mcnt_d  = '0;
        flags_d = '0;
        cycle_d = '0;
        pri_d   = '0;
        swst_d  = '0;
        win_d   = '0;
      end
      if (pos_q == isp_hdr_pkg::P_LEN_HI || pos_q == isp_hdr_pkg::P_LEN_LO) begin
        len_d = {len_q[7:0], byte_i};
      end
      if (pos_q == isp_hdr_pkg::P_DFH_HI || pos_q == isp_hdr_pkg::P_DFH_LO) begin
        dfh_d = {dfh_q[7:0], byte_i};
      end
      if (pos_q == isp_hdr_pkg::P_DFH_LO && !skip_q && dfh_d != isp_hdr_pkg::DFH_LEN) begin
        res_valid_d = 1'b1;
        res_d.kind  = isp_hdr_pkg::RES_ERROR;
        res_d.err   = isp_hdr_pkg::ERR_DFH_LEN;
        skip_d      = 1'b1;
      end
      if (pos_q == isp_hdr_pkg::P_MODE_ID && !skip_q && byte_i != isp_hdr_pkg::MODE_IM) begin
        res_valid_d = 1'b1;
        res_d.kind  = isp_hdr_pkg::RES_ERROR;
        res_d.err   = isp_hdr_pkg::ERR_MODE_ID;
        skip_d      = 1'b1;
      end
      if (pos_q >= isp_hdr_pkg::P_TIME_FIRST && pos_q <= isp_hdr_pkg::P_TIME_LAST) begin
        time_d = {time_q[31:0], byte_i};
      end
      if (pos_q >= isp_hdr_pkg::P_MCNT_FIRST && pos_q <= isp_hdr_pkg::P_MCNT_LAST) begin
        mcnt_d = {mcnt_q[15:0], byte_i};
      end
      if (pos_q == isp_hdr_pkg::P_FLAGS) begin
        flags_d = byte_i[7:4];
        cycle_d = {byte_i[3:0], cycle_q[7:0]};
      end
      if (pos_q == isp_hdr_pkg::P_CYCLE_LO) begin
        cycle_d = {cycle_q[11:8], byte_i};
      end
      if (pos_q == isp_hdr_pkg::P_PRI_HI)  pri_d  = {byte_i, pri_q[7:0]};
      if (pos_q == isp_hdr_pkg::P_PRI_LO)  pri_d  = {pri_q[15:8], byte_i};
      if (pos_q == isp_hdr_pkg::P_SWST_HI) swst_d = {byte_i, swst_q[7:0]};
      if (pos_q == isp_hdr_pkg::P_SWST_LO) swst_d = {swst_q[15:8], byte_i};
      if (pos_q == isp_hdr_pkg::P_WIN_HI)  win_d  = {byte_i, win_q[7:0]};
      if (pos_q == isp_hdr_pkg::P_WIN_LO)  win_d  = {win_q[15:8], byte_i};

      if (pos_q == isp_hdr_pkg::P_LAST) begin
        if (!skip_q) begin
          res_valid_d         = 1'b1;
          res_d.kind          = isp_hdr_pkg::RES_HEADER;
          res_d.board_time    = time_q;
          res_d.mode_counter  = mcnt_q;
          res_d.flag_bits     = flags_q;
          res_d.cycle_counter = cycle_q;
          res_d.pri_value     = pri_q;
          res_d.swst_value    = swst_q;
          res_d.window_length = win_q;
          // Drop the data field of non-echo packets.
          if (!flags_q[3]) begin
            skip_d = 1'b1;
          end
        end
        pos_d = '0;
        if (len_q <= isp_hdr_pkg::DFH_LEN) begin
          in_data_d = 1'b0;
          skip_d    = 1'b0;
        end else begin
          in_data_d = 1'b1;
          rem_d     = len_q - isp_hdr_pkg::DFH_LEN;
          blk_off_d = '0;
        end
      end else begin
        pos_d = pos_q + isp_hdr_pkg::HDR_POS_W'(1);
      end
    end else if (accept_i) begin
      if (blk_off_q == '0) begin
        full_now   = (rem_q >= BlkLen);
        blk_full_d = full_now;
        if (full_now && !skip_q) begin
          blk_id_d = byte_i;
        end
      end else if (blk_full_q && !skip_q) begin
        rd_o.en           = 1'b1;
        rd_o.i_addr       = {isp_hdr_pkg::map_code(byte_i[7:4]), blk_id_q};
        rd_o.q_addr       = {isp_hdr_pkg::map_code(byte_i[3:0]), blk_id_q};
        res_valid_d       = 1'b1;
        res_d.kind        = isp_hdr_pkg::RES_SAMPLE;
        res_d.last_sample = (blk_off_q == BlkOffLast) && (rem_q <= BlkLen);
      end
      blk_off_d = (blk_off_q == BlkOffLast) ? '0 : blk_off_q + isp_hdr_pkg::BLK_OFF_W'(1);
      if (rem_q == RemOne) begin
        in_data_d = 1'b0;
        skip_d    = 1'b0;
        pos_d     = '0;
      end else begin
        rem_d = rem_q - RemOne;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      in_data_q   <= 1'b0;
      skip_q      <= 1'b0;
      rem_q       <= '0;
      blk_off_q   <= '0;
      blk_full_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      in_data_q   <= in_data_d;
      skip_q      <= skip_d;
      rem_q       <= rem_d;
      blk_off_q   <= blk_off_d;
      blk_full_q  <= blk_full_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q    <= len_d;
    dfh_q    <= dfh_d;
    time_q   <= time_d;
    mcnt_q   <= mcnt_d;
    flags_q  <= flags_d;
    cycle_q  <= cycle_d;
    pri_q    <= pri_d;
    swst_q   <= swst_d;
    win_q    <= win_d;
    blk_id_q <= blk_id_d;
    res_q    <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `ISP_HDR_ASSERT(a_res_after_byte, res_valid_q |-> $past(accept_i), "result without byte")
  `ISP_HDR_ASSERT_NEVER(a_rem_nonzero, in_data_q && (rem_q == '0), "data phase with no bytes left")
  `ISP_HDR_ASSERT(a_read_gives_sample, rd_o.en |=> (res_valid_q && res_q.kind == isp_hdr_pkg::RES_SAMPLE), "table read without sample")

endmodule

FILE: design/isp_hdr_outq.sv
`timescale 1ns / 1ps
`include "isp_header_parse_fbaq4_decode_unit_defines.svh"

module isp_hdr_outq (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  isp_hdr_pkg::result_t              push_data_i,
  input  logic                              stall_i,
  output logic                              valid_o,
  output isp_hdr_pkg::result_t              data_o,
  output logic [isp_hdr_pkg::OQ_CNT_W-1:0]  count_o
);

  localparam logic [isp_hdr_pkg::OQ_PTR_W-1:0] PtrLast =
    isp_hdr_pkg::OQ_PTR_W'(isp_hdr_pkg::OQ_DEPTH - 1);
  localparam logic [isp_hdr_pkg::OQ_CNT_W-1:0] CntFull =
    isp_hdr_pkg::OQ_CNT_W'(isp_hdr_pkg::OQ_DEPTH);

  isp_hdr_pkg::result_t                ent_q [isp_hdr_pkg::OQ_DEPTH];
  logic [isp_hdr_pkg::OQ_PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [isp_hdr_pkg::OQ_PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [isp_hdr_pkg::OQ_CNT_W-1:0]    cnt_q, cnt_d;
  logic                                pop;

  assign pop = (cnt_q != '0) && !stall_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + isp_hdr_pkg::OQ_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + isp_hdr_pkg::OQ_PTR_W'(1);
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + isp_hdr_pkg::OQ_CNT_W'(1);
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - isp_hdr_pkg::OQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = ent_q[rd_ptr_q];
  assign count_o = cnt_q;

  `ISP_HDR_ASSERT_NEVER(a_no_overflow, push_i && !pop && (cnt_q == CntFull), "result queue overflow")

endmodule

FILE: design/isp_header_parse_fbaq4_decode_unit.sv
`timescale 1ns / 1ps

// Channel | Direction | Handshake               | Payload
// --------+-----------+-------------------------+---------------------------------------
// in      | input     | in_valid_i / in_stall_o | req_type, stream_byte, table_addr, I/Q
// out     | output    | out_valid_o/out_stall_i | result kind, header fields, I/Q sample
//
// One item per cycle while in_stall_o is low. A result is registered in the
// parser stage, next to its table read data, and then in the result queue.
// The I and Q tables are single-port-read synchronous memories; a table
// write and a lookup never fall in the same cycle, so no forwarding is needed.
// Reset clears the parser state at once; the tables are not cleared and hold
// undefined data until written, so there is no clearing pass.
// in_stall_o rises when the three-entry result queue plus the result in
// flight would fill it, which only happens once out has been stalled.

module isp_header_parse_fbaq4_decode_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           req_type_i,
  input  logic [7:0]                     stream_byte_i,
  input  logic [isp_hdr_pkg::TBL_AW-1:0] table_addr_i,
  input  logic [isp_hdr_pkg::WORD_W-1:0] i_table_word_i,
  input  logic [isp_hdr_pkg::WORD_W-1:0] q_table_word_i,

  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     result_kind_o,
  output logic [1:0]                     error_code_o,
  output logic [39:0]                    onboard_time_o,
  output logic [23:0]                    mode_counter_o,
  output logic [3:0]                     flag_bits_o,
  output logic [11:0]                    cycle_counter_o,
  output logic [15:0]                    pri_value_o,
  output logic [15:0]                    swst_value_o,
  output logic [15:0]                    window_length_o,
  output logic [isp_hdr_pkg::WORD_W-1:0] i_sample_o,
  output logic [isp_hdr_pkg::WORD_W-1:0] q_sample_o,
  output logic                           last_sample_o
);

  localparam logic [isp_hdr_pkg::OQ_CNT_W:0] OccFull =
    (isp_hdr_pkg::OQ_CNT_W + 1)'(isp_hdr_pkg::OQ_DEPTH);

  logic                              xfer_in;
  logic                              byte_xfer;
  isp_hdr_pkg::lut_wr_t              lut_wr;
  isp_hdr_pkg::lut_rd_t              lut_rd;
  logic [isp_hdr_pkg::WORD_W-1:0]    i_rdata;
  logic [isp_hdr_pkg::WORD_W-1:0]    q_rdata;
  logic                              res_valid;
  isp_hdr_pkg::result_t              res;
  isp_hdr_pkg::result_t              push_res;
  isp_hdr_pkg::result_t              head;
  logic [isp_hdr_pkg::OQ_CNT_W-1:0]  q_count;
  logic [isp_hdr_pkg::OQ_CNT_W:0]    occupancy;

  // Count the result still in the parser stage so the queue always has room
  // for it and for whatever the next transfer produces.
  assign occupancy  = {1'b0, q_count} + {{isp_hdr_pkg::OQ_CNT_W{1'b0}}, res_valid};
  assign in_stall_o = (occupancy >= OccFull);
  assign xfer_in    = in_valid_i && !in_stall_o;

  // Split the request kinds: table writes go straight to the memories,
  // stream bytes advance the parser.
  assign byte_xfer = xfer_in && (req_type_i == isp_hdr_pkg::REQ_STREAM);

  always_comb begin
    lut_wr        = '0;
    lut_wr.en     = xfer_in && (req_type_i == isp_hdr_pkg::REQ_TABLE);
    lut_wr.addr   = table_addr_i;
    lut_wr.i_word = i_table_word_i;
    lut_wr.q_word = q_table_word_i;
  end

  isp_hdr_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (byte_xfer),
    .byte_i      (stream_byte_i),
    .rd_o        (lut_rd),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  isp_hdr_lut u_lut (
    .clk_i     (clk_i),
    .wr_i      (lut_wr),
    .rd_i      (lut_rd),
    .i_rdata_o (i_rdata),
    .q_rdata_o (q_rdata)
  );

  // Merge the table read data into sample results as they enter the queue.
  always_comb begin
    push_res = res;
    if (res.kind == isp_hdr_pkg::RES_SAMPLE) begin
      push_res.i_recon = i_rdata;
      push_res.q_recon = q_rdata;
    end
  end

  isp_hdr_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (push_res),
    .stall_i     (out_stall_i),
    .valid_o     (out_valid_o),
    .data_o      (head),
    .count_o     (q_count)
  );

  assign result_kind_o   = head.kind;
  assign error_code_o    = head.err;
  assign onboard_time_o  = head.board_time;
  assign mode_counter_o  = head.mode_counter;
  assign flag_bits_o     = head.flag_bits;
  assign cycle_counter_o = head.cycle_counter;
  assign pri_value_o     = head.pri_value;
  assign swst_value_o    = head.swst_value;
  assign window_length_o = head.window_length;
  assign i_sample_o      = head.i_recon;
  assign q_sample_o      = head.q_recon;
  assign last_sample_o   = head.last_sample;

endmodule
